[sv/ttu_pkg.sv]
package ttu_pkg;

	// block normalization puts the largest magnitude in [2^29, 2^30)
	localparam int unsigned NORM_BITS = 30;
	localparam int unsigned THRESH_W = 31;
	localparam logic [THRESH_W-1:0] THRESH_RESET = 31'd2684;
	localparam logic [15:0] OUT_MAX_MAG = 16'd32767;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_UNRESOLVED = 2'd1,
		ST_DEGENERATE = 2'd2,
		ST_ZERO_LEN   = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [31:0] edge_a_x;
		logic signed [31:0] edge_a_y;
		logic signed [31:0] edge_a_z;
		logic signed [31:0] edge_b_x;
		logic signed [31:0] edge_b_y;
		logic signed [31:0] edge_b_z;
		logic signed [15:0] tex_a_u;
		logic signed [15:0] tex_a_v;
		logic signed [15:0] tex_b_u;
		logic signed [15:0] tex_b_v;
		logic               tex_resolved;
	} tri_req_t;

	typedef struct packed {
		logic signed [15:0] tangent_x;
		logic signed [15:0] tangent_y;
		logic signed [15:0] tangent_z;
		status_t            status;
	} tan_rsp_t;

endpackage

[sv/triangle_tangent_unit.sv]
// Per-triangle unit tangent. Fully pipelined: one triangle enters per cycle. The
// pipeline is six stages of products, normalization and squaring, the square root at
// one result bit per stage over 31 stages, one stage loading the three parallel
// dividers, the dividers at one quotient bit per stage over OUT_FRAC_BITS + 1 stages,
// and the output register. When a result is not taken the whole pipeline holds, so a
// new request is taken only in cycles where the output register is empty or being
// read. The threshold register is written through cfg_*; the user must write it only
// while the unit is idle, which the block itself does not enforce. cfg_ready is
// always high.
module triangle_tangent_unit import ttu_pkg::*; #(
	parameter int unsigned OUT_FRAC_BITS = 14
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tri_valid,
	output logic                tri_ready,
	input  tri_req_t            tri_data,
	output logic                tan_valid,
	input  logic                tan_ready,
	output tan_rsp_t            tan_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [THRESH_W-1:0] cfg_data
);

	localparam int unsigned MAG_W  = 48;
	localparam int unsigned NB     = NORM_BITS;
	localparam int unsigned SQR_W  = 2 * NB;
	localparam int unsigned SUM_W  = SQR_W + 2;
	localparam int unsigned ROOT_W = SUM_W / 2;
	localparam int unsigned QW     = OUT_FRAC_BITS + 1;
	localparam int unsigned NW     = ROOT_W + OUT_FRAC_BITS + 1;
	localparam int unsigned BL_W   = $clog2(MAG_W + 1);

	typedef struct packed {
		logic [2:0][NB-1:0] mag;
		logic [2:0]         neg;
		status_t            status;
	} carry_t;

	logic en;
	assign en = !tan_valid || tan_ready;
	assign tri_ready = en;
	assign cfg_ready = 1'b1;

	logic [THRESH_W-1:0] thresh_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_valid) begin
			thresh_q <= cfg_data;
		end
	end

	// stage 1: products
	logic                     v_s1, res_s1;
	logic signed [31:0]       pd1_s1, pd2_s1;
	logic signed [2:0][47:0]  pa_s1, pb_s1;
	logic signed [31:0]       ea [3];
	logic signed [31:0]       eb [3];

	assign ea[0] = tri_data.edge_a_x;
	assign ea[1] = tri_data.edge_a_y;
	assign ea[2] = tri_data.edge_a_z;
	assign eb[0] = tri_data.edge_b_x;
	assign eb[1] = tri_data.edge_b_y;
	assign eb[2] = tri_data.edge_b_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= tri_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s1 <= tri_data.tex_resolved;
			pd1_s1 <= tri_data.tex_a_u * tri_data.tex_b_v;
			pd2_s1 <= tri_data.tex_b_u * tri_data.tex_a_v;
			for (int i = 0; i < 3; i++) begin
				pa_s1[i] <= 48'(tri_data.tex_b_v) * 48'(ea[i]);
				pb_s1[i] <= 48'(tri_data.tex_a_v) * 48'(eb[i]);
			end
		end
	end

	// stage 2: determinant, raw tangent, early status
	logic                     v_s2;
	logic [2:0][MAG_W-1:0]    mag_s2;
	logic [2:0]               neg_s2;
	status_t                  st_s2;
	logic signed [32:0]       det;
	logic [32:0]              adet;
	logic signed [48:0]       cc [3];

	always_comb begin
		det  = 33'(pd1_s1) - 33'(pd2_s1);
		adet = det[32] ? 33'(-det) : 33'(det);
		for (int i = 0; i < 3; i++) begin
			cc[i] = 49'($signed(pa_s1[i])) - 49'($signed(pb_s1[i]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_s2[i] <= cc[i][48] ? MAG_W'(-cc[i]) : MAG_W'(cc[i]);
				neg_s2[i] <= (cc[i] != '0) && (cc[i][48] ^ det[32]);
			end
			if (!res_s1) begin
				st_s2 <= ST_UNRESOLVED;
			end else if (adet <= 33'(thresh_q)) begin
				st_s2 <= ST_DEGENERATE;
			end else begin
				st_s2 <= ST_OK;
			end
		end
	end

	// stage 3: bit length of the largest magnitude
	logic                     v_s3;
	logic [2:0][MAG_W-1:0]    mag_s3;
	logic [2:0]               neg_s3;
	status_t                  st_s3;
	logic [BL_W-1:0]          bl_s3;
	logic [MAG_W-1:0]         orv;
	logic [BL_W-1:0]          bl;

	always_comb begin
		orv = mag_s2[0] | mag_s2[1] | mag_s2[2];
		bl  = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (orv[i]) begin
				bl = BL_W'(i + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
			bl_s3  <= bl;
			st_s3  <= (st_s2 == ST_OK && orv == '0) ? ST_ZERO_LEN : st_s2;
		end
	end

	// stage 4: shift all three by the same amount
	logic                  v_s4;
	carry_t                c_s4;
	logic [NB+MAG_W-1:0]   wide [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wide[i] = {mag_s3[i], NB'(0)} >> bl_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				c_s4.mag[i] <= wide[i][NB-1:0];
			end
			c_s4.neg    <= neg_s3;
			c_s4.status <= st_s3;
		end
	end

	// stage 5: squares
	logic                  v_s5;
	carry_t                c_s5;
	logic [2:0][SQR_W-1:0] sqr_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s5 <= c_s4;
			for (int i = 0; i < 3; i++) begin
				sqr_s5[i] <= c_s4.mag[i] * c_s4.mag[i];
			end
		end
	end

	// stage 6: sum of squares
	logic                  v_s6;
	carry_t                c_s6;
	logic [SUM_W-1:0]      sum_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s6   <= c_s5;
			sum_s6 <= SUM_W'(sqr_s5[0]) + SUM_W'(sqr_s5[1]) + SUM_W'(sqr_s5[2]);
		end
	end

	// square root, one root bit per stage, residual d = sum - r^2
	logic              sq_v [ROOT_W+1];
	carry_t            sq_c [ROOT_W+1];
	logic [SUM_W-1:0]  sq_d [ROOT_W+1];
	logic [ROOT_W-1:0] sq_r [ROOT_W+1];

	assign sq_v[0] = v_s6;
	assign sq_c[0] = c_s6;
	assign sq_d[0] = sum_s6;
	assign sq_r[0] = '0;

	for (genvar s = 0; s < ROOT_W; s++) begin : g_sqrt
		localparam int unsigned K = ROOT_W - 1 - s;
		logic [SUM_W:0] trial;
		logic           take;

		always_comb begin
			trial = ((SUM_W+1)'({sq_r[s], 1'b0}) + ((SUM_W+1)'(1) << K)) << K;
			take  = (SUM_W+1)'(sq_d[s]) >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[s+1] <= 1'b0;
			end else if (en) begin
				sq_v[s+1] <= sq_v[s];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_c[s+1] <= sq_c[s];
				sq_d[s+1] <= take ? SUM_W'((SUM_W+1)'(sq_d[s]) - trial) : sq_d[s];
				sq_r[s+1] <= take ? (sq_r[s] | (ROOT_W'(1) << K)) : sq_r[s];
			end
		end
	end

	// dividers: numerator m * 2^OUT_FRAC_BITS + len/2, one quotient bit per stage
	logic                 dv_v   [QW+1];
	carry_t               dv_c   [QW+1];
	logic [ROOT_W-1:0]    dv_len [QW+1];
	logic [2:0][NW-1:0]   dv_rem [QW+1];
	logic [2:0][QW-1:0]   dv_q   [QW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else if (en) begin
			dv_v[0] <= sq_v[ROOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_c[0]   <= sq_c[ROOT_W];
			dv_len[0] <= sq_r[ROOT_W];
			dv_q[0]   <= '0;
			for (int i = 0; i < 3; i++) begin
				dv_rem[0][i] <= (NW'(sq_c[ROOT_W].mag[i]) << OUT_FRAC_BITS)
					+ NW'(sq_r[ROOT_W] >> 1);
			end
		end
	end

	for (genvar s = 0; s < QW; s++) begin : g_div
		localparam int unsigned K = QW - 1 - s;
		logic [NW-1:0] dsh;

		assign dsh = NW'(dv_len[s]) << K;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[s+1] <= 1'b0;
			end else if (en) begin
				dv_v[s+1] <= dv_v[s];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_c[s+1]   <= dv_c[s];
				dv_len[s+1] <= dv_len[s];
				for (int i = 0; i < 3; i++) begin
					if (dv_rem[s][i] >= dsh) begin
						dv_rem[s+1][i] <= dv_rem[s][i] - dsh;
						dv_q[s+1][i]   <= dv_q[s][i] | (QW'(1) << K);
					end else begin
						dv_rem[s+1][i] <= dv_rem[s][i];
						dv_q[s+1][i]   <= dv_q[s][i];
					end
				end
			end
		end
	end

	// output register: saturate, apply sign, zero on fault
	logic [15:0] comp [3];
	logic        fault;

	always_comb begin
		fault = dv_c[QW].status != ST_OK;
		for (int i = 0; i < 3; i++) begin
			if ((QW+16)'(dv_q[QW][i]) > (QW+16)'(OUT_MAX_MAG)) begin
				comp[i] = OUT_MAX_MAG;
			end else begin
				comp[i] = 16'(dv_q[QW][i]);
			end
			if (fault) begin
				comp[i] = '0;
			end else if (dv_c[QW].neg[i]) begin
				comp[i] = -comp[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tan_valid <= 1'b0;
		end else if (en) begin
			tan_valid <= dv_v[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tan_data.tangent_x <= comp[0];
			tan_data.tangent_y <= comp[1];
			tan_data.tangent_z <= comp[2];
			tan_data.status    <= dv_c[QW].status;
		end
	end

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		tan_valid && tan_data.status != ST_OK |->
			tan_data.tangent_x == '0 && tan_data.tangent_y == '0 && tan_data.tangent_z == '0)
		else $error("faulted tangent is not zero");

	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		tan_valid && tan_data.status == ST_OK |->
			tan_data.tangent_x != '0 || tan_data.tangent_y != '0 || tan_data.tangent_z != '0)
		else $error("valid tangent is all zero");

	a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!tri_ready |-> tan_valid && !tan_ready)
		else $error("request refused without output backpressure");

	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		tan_valid && !tan_ready |=> $stable(dv_v[QW]) && $stable(v_s1))
		else $error("pipeline moved during stall");

endmodule
